// ----- sv/reflt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflt_pkg
// shared types and byte codes of the radio event frame link tracker
// ----------------------------------------------------------------------------
package reflt_pkg;

   localparam logic [7:0] BYTE_STX   = 8'h02;
   localparam logic [7:0] BYTE_IND   = 8'h69;
   localparam logic [7:0] OP_READY   = 8'h25;
   localparam logic [7:0] OP_ESTAB   = 8'h0C;
   localparam logic [7:0] OP_TRANSP  = 8'h11;
   localparam logic [7:0] OP_RELEASE = 8'h0E;
   localparam logic [7:0] BYTE_ETX   = 8'h03;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_TYPE   = 3'd1,
      PH_OPCODE = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_LEN_HI = 3'd4,
      PH_SUM    = 3'd5,
      PH_DATA   = 3'd6,
      PH_END    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      LINK_UNINIT = 2'd0,
      LINK_NOCONN = 2'd1,
      LINK_CONN   = 2'd2
   } link_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_READY   = 3'd1,
      EV_ESTAB   = 3'd2,
      EV_TRANSP  = 3'd3,
      EV_RELEASE = 3'd4
   } event_type;

   typedef struct packed {
      phase_type   phase;
      event_type   held_event;
      logic [7:0]  running_sum;
      logic [15:0] remaining;
      link_type    link;
   } track_state_type;

   typedef struct packed {
      link_type  link_status;
      event_type frame_event;
      logic      flush_rx;
   } track_result_type;

   localparam track_state_type STATE_RESET = '{
      phase:       PH_START,
      held_event:  EV_NONE,
      running_sum: 8'h00,
      remaining:   16'h0000,
      link:        LINK_UNINIT
   };

endpackage

// ----- sv/reflt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflt_step
// per-byte frame parser and link status update, purely combinational
// ----------------------------------------------------------------------------
module reflt_step (
   input  reflt_pkg::track_state_type  cur_state,
   input  logic [7:0]                  rx_byte,
   input  logic                        framing_error,
   output reflt_pkg::track_state_type  nxt_state,
   output reflt_pkg::track_result_type result
);
   import reflt_pkg::*;

   function automatic event_type opcode_event(input logic [7:0] b);
      event_type e;
      case (b)
         OP_READY:   e = EV_READY;
         OP_ESTAB:   e = EV_ESTAB;
         OP_TRANSP:  e = EV_TRANSP;
         OP_RELEASE: e = EV_RELEASE;
         default:    e = EV_NONE;
      endcase
      return e;
   endfunction

   track_state_type parsed;
   event_type       ev;
   event_type       op_ev;
   logic            flush;

   assign op_ev = opcode_event(rx_byte);

   // frame parser
   always_comb begin
      parsed = cur_state;
      ev     = EV_NONE;
      case (cur_state.phase)
         PH_START: begin
            if (rx_byte == BYTE_STX) parsed.phase = PH_TYPE;
         end
         PH_TYPE: begin
            parsed.phase = (rx_byte == BYTE_IND) ? PH_OPCODE : PH_START;
         end
         PH_OPCODE: begin
            if (op_ev != EV_NONE) begin
               parsed.held_event  = op_ev;
               parsed.running_sum = BYTE_IND + rx_byte;
               parsed.phase       = PH_LEN_LO;
            end else begin
               parsed.phase = PH_START;
            end
         end
         PH_LEN_LO: begin
            parsed.remaining   = {8'h00, rx_byte};
            parsed.running_sum = cur_state.running_sum + rx_byte;
            parsed.phase       = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            parsed.remaining   = {rx_byte, cur_state.remaining[7:0]};
            parsed.running_sum = cur_state.running_sum + rx_byte;
            parsed.phase       = PH_SUM;
         end
         PH_SUM: begin
            parsed.phase = (rx_byte == cur_state.running_sum) ? PH_DATA : PH_START;
         end
         PH_DATA: begin
            // zero length behaves like a length of one
            if (cur_state.remaining <= 16'd1) begin
               parsed.remaining = 16'd0;
               parsed.phase     = PH_END;
            end else begin
               parsed.remaining = cur_state.remaining - 16'd1;
            end
         end
         PH_END: begin
            parsed.phase = PH_START;
            if (rx_byte == BYTE_ETX) ev = cur_state.held_event;
         end
         default: begin
            parsed.phase = PH_START;
         end
      endcase
   end

   // link status follows completed frames
   always_comb begin
      nxt_state = parsed;
      flush     = 1'b0;
      case (cur_state.link)
         LINK_UNINIT: begin
            if (ev == EV_READY) nxt_state.link = LINK_NOCONN;
         end
         LINK_NOCONN: begin
            if (ev == EV_ESTAB) begin
               nxt_state.link = LINK_CONN;
               flush          = 1'b1;
            end
         end
         LINK_CONN: begin
            if (ev == EV_RELEASE) begin
               nxt_state.link = LINK_NOCONN;
               flush          = 1'b1;
            end
         end
         default: begin
            nxt_state.link = cur_state.link;
         end
      endcase

      // a byte with a framing error leaves everything alone
      if (framing_error) begin
         nxt_state = cur_state;
      end
   end

   assign result.link_status = nxt_state.link;
   assign result.frame_event = framing_error ? EV_NONE : ev;
   assign result.flush_rx    = framing_error ? 1'b0 : flush;

endmodule

// ----- sv/radio_event_frame_link_tracker_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_event_frame_link_tracker_top
// parses indication frames from received serial bytes and tracks link status
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  req_     | in        | req_valid/ready    | rx_byte[7:0], framing_error
//  rsp_     | out       | rsp_valid/ready    | link_status[1:0], frame_event[2:0],
//           |           |                    | flush_rx
//
//  one transaction per cycle while results are taken; each accepted byte gives exactly one result
//  on the following cycle, set by the single parser/link update stage
//  synchronous reset returns the parser to waiting for the start byte,
//  the link to uninitialized and empties the result register
//  while the result register is full and rsp_ready is low, req_ready is low;
//  otherwise a new byte is taken in the same cycle the old result leaves
//
module radio_event_frame_link_tracker_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_framing_error,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_link_status,
   output logic [2:0] rsp_frame_event,
   output logic       rsp_flush_rx
);
   import reflt_pkg::*;

   track_state_type  state_ff;
   track_state_type  state_in;
   track_result_type result_ff;
   track_result_type result_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             req_fire;

   // output register frees up when empty or when being taken this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   reflt_step u_step (
      .cur_state     (state_ff),
      .rx_byte       (req_rx_byte),
      .framing_error (req_framing_error),
      .nxt_state     (state_in),
      .result        (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) state_ff <= state_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link_status = result_ff.link_status;
   assign rsp_frame_event = result_ff.frame_event;
   assign rsp_flush_rx    = result_ff.flush_rx;

   // flush only goes with a link established or released event
   a_flush_event : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.flush_rx |->
         (result_ff.frame_event == EV_ESTAB || result_ff.frame_event == EV_RELEASE))
      else $error("flush without link change event");

   // a byte with a framing error changes no state
   a_ferr_hold : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_framing_error |=> state_ff == $past(state_ff))
      else $error("framing error byte altered parser state");

   // reported link status matches the tracker state after the transaction
   a_link_match : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> result_ff.link_status == state_ff.link)
      else $error("result link status differs from tracked link");

   // a full result register that is not taken blocks new bytes
   a_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("byte accepted while result stalled");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the radio event frame link tracker: a queue of
// serial bytes (good frames, broken frames, noise, framing errors) feeds a
// clocked driver; a clocked monitor compares every result with a local
// model of the frame parser and link status, under random idling on both sides
// ----------------------------------------------------------------------------
module tb;
   import reflt_pkg::*;

   // one queued byte for the req_ channel
   typedef struct {
      logic [7:0] rx_byte;
      logic       framing_error;
      bit         hold;   // wait for all pending results before sending
      bit         fast;   // part of a long frame, no idling on either side
   } rx_item_type;

   localparam logic [7:0] OPCODES [4] = '{OP_READY, OP_ESTAB, OP_TRANSP, OP_RELEASE};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_framing_error = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_link_status;
   logic [2:0] rsp_frame_event;
   logic       rsp_flush_rx;

   rx_item_type      pending_bytes[$];
   track_result_type expected_results[$];

   // local copy of the parser and link state
   phase_type   trk_phase = PH_START;
   event_type   trk_event = EV_NONE;
   logic [7:0]  trk_sum = 8'h00;
   logic [15:0] trk_remaining = 16'h0000;
   link_type    trk_link = LINK_UNINIT;

   int error_count = 0;
   int good_bytes = 0;
   int send_gap = 0;
   int recv_stall = 0;
   bit send_burst = 0;
   bit recv_burst = 0;
   bit rush = 0;
   bit stim_hold = 0;
   bit stim_fast = 0;
   int ferr_pct = 0;

   radio_event_frame_link_tracker_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_framing_error (req_framing_error),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_link_status   (rsp_link_status),
      .rsp_frame_event   (rsp_frame_event),
      .rsp_flush_rx      (rsp_flush_rx)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // frame parser and link status model, one call per accepted byte
   // ---------------------------------------------------------------------
   task automatic track_byte(input logic [7:0] b, input logic ferr);
      event_type ev;
      event_type op_ev;
      logic      flush;
      ev = EV_NONE;
      flush = 1'b0;
      // a byte with a framing error leaves every bit of state alone
      if (!ferr) begin
         case (trk_phase)
            PH_START: begin
               if (b == BYTE_STX) trk_phase = PH_TYPE;
            end
            PH_TYPE: begin
               // a bad type byte is not looked at again as a start byte
               if (b == BYTE_IND) trk_phase = PH_OPCODE;
               else trk_phase = PH_START;
            end
            PH_OPCODE: begin
               case (b)
                  OP_READY:   op_ev = EV_READY;
                  OP_ESTAB:   op_ev = EV_ESTAB;
                  OP_TRANSP:  op_ev = EV_TRANSP;
                  OP_RELEASE: op_ev = EV_RELEASE;
                  default:    op_ev = EV_NONE;
               endcase
               if (op_ev != EV_NONE) begin
                  trk_event = op_ev;
                  trk_sum = BYTE_IND + b;
                  trk_phase = PH_LEN_LO;
               end else begin
                  trk_phase = PH_START;
               end
            end
            PH_LEN_LO: begin
               trk_remaining = {8'h00, b};
               trk_sum = trk_sum + b;
               trk_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               trk_remaining = {b, trk_remaining[7:0]};
               trk_sum = trk_sum + b;
               trk_phase = PH_SUM;
            end
            PH_SUM: begin
               if (b == trk_sum) trk_phase = PH_DATA;
               else trk_phase = PH_START;
            end
            PH_DATA: begin
               // zero length still eats one payload byte
               if (trk_remaining <= 16'd1) begin
                  trk_remaining = 16'h0000;
                  trk_phase = PH_END;
               end else begin
                  trk_remaining = trk_remaining - 16'd1;
               end
            end
            default: begin
               trk_phase = PH_START;
               if (b == BYTE_ETX) ev = trk_event;
            end
         endcase
         // events that do not fit the current status are reported only
         case (trk_link)
            LINK_UNINIT: begin
               if (ev == EV_READY) trk_link = LINK_NOCONN;
            end
            LINK_NOCONN: begin
               if (ev == EV_ESTAB) begin
                  trk_link = LINK_CONN;
                  flush = 1'b1;
               end
            end
            LINK_CONN: begin
               if (ev == EV_RELEASE) begin
                  trk_link = LINK_NOCONN;
                  flush = 1'b1;
               end
            end
            default: ;
         endcase
      end
      expected_results.push_back('{link_status: trk_link, frame_event: ev, flush_rx: flush});
   endtask

   // ---------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic ferr);
      rx_item_type item;
      item.rx_byte = b;
      item.framing_error = ferr;
      item.hold = stim_hold;
      item.fast = stim_fast;
      stim_hold = 0;
      if (!ferr) good_bytes++;
      pending_bytes.push_back(item);
   endtask

   // good byte, now and then preceded by a corrupted one
   task automatic push_good(input logic [7:0] b);
      logic [7:0] junk;
      if ($urandom_range(0, 99) < ferr_pct) begin
         junk = 8'($urandom_range(0, 255));
         push_byte(junk, 1'b1);
      end
      push_byte(b, 1'b0);
   endtask

   // a nonzero sum_flip spoils the checksum and cuts the frame after it
   task automatic push_frame(input logic [7:0] op, input logic [15:0] len,
                             input logic [7:0] sum_flip, input logic [7:0] end_byte);
      logic [7:0] sum;
      logic [7:0] data;
      int         count;
      sum = BYTE_IND + op;
      sum = sum + len[7:0];
      sum = sum + len[15:8];
      push_good(BYTE_STX);
      push_good(BYTE_IND);
      push_good(op);
      push_good(len[7:0]);
      push_good(len[15:8]);
      push_good(sum ^ sum_flip);
      if (sum_flip == 8'h00) begin
         count = (len == 16'h0000) ? 1 : int'(len);
         for (int i = 0; i < count; i++) begin
            data = 8'($urandom_range(0, 255));
            push_good(data);
         end
         push_good(end_byte);
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: presents queued bytes, predicts at each accepted transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : driver
      rx_item_type item;
      logic        valid_next;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         valid_next = req_valid;
         if (req_valid && req_ready) begin
            track_byte(req_rx_byte, req_framing_error);
            valid_next = 1'b0;
         end
         if (!valid_next && pending_bytes.size() != 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!(pending_bytes[0].hold && expected_results.size() != 0)) begin
               item = pending_bytes.pop_front();
               req_rx_byte <= item.rx_byte;
               req_framing_error <= item.framing_error;
               valid_next = 1'b1;
               rush = item.fast;
               // occasional stretches with no idling at all
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_gap = (item.fast || send_burst) ? 0 : int'($urandom_range(0, 18));
            end
         end
         req_valid <= valid_next;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random stalls on rsp_ready, checks every result transaction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      track_result_type want;
      logic             ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         ready_next = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: link_status %0d frame_event %0d flush_rx %0d",
                        $time, rsp_link_status, rsp_frame_event, rsp_flush_rx);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (want.link_status !== rsp_link_status) begin
                  $display("%0t: link_status mismatch: expected %0d, actual %0d",
                           $time, want.link_status, rsp_link_status);
                  error_count++;
               end
               if (want.frame_event !== rsp_frame_event) begin
                  $display("%0t: frame_event mismatch: expected %0d, actual %0d",
                           $time, want.frame_event, rsp_frame_event);
                  error_count++;
               end
               if (want.flush_rx !== rsp_flush_rx) begin
                  $display("%0t: flush_rx mismatch: expected %0d, actual %0d",
                           $time, want.flush_rx, rsp_flush_rx);
                  error_count++;
               end
            end
            ready_next = 1'b0;
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_stall = (rush || recv_burst) ? 0 : int'($urandom_range(0, 18));
         end
         if (!ready_next) begin
            if (recv_stall > 0) recv_stall--;
            else ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int         kind;
      int         noise_len;
      logic [7:0] op;
      logic [7:0] b;
      logic [7:0] end_byte;
      logic [15:0] len;

      // directed: framing error while idle, all-ones and all-zeros bytes
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      // established while uninitialized: reported, status unchanged
      push_frame(OP_ESTAB, 16'h0000, 8'h00, BYTE_ETX);
      // ready with one payload byte and a corrupted byte in the middle
      push_good(BYTE_STX);
      push_good(BYTE_IND);
      push_good(OP_READY);
      push_good(8'h01);
      push_good(8'h00);
      push_byte(8'h55, 1'b1);
      push_good(8'h8F);
      push_good(8'hA5);
      push_good(BYTE_ETX);
      // start byte in the type slot is not taken as a new start
      push_good(BYTE_STX);
      push_good(BYTE_STX);
      push_good(BYTE_IND);
      push_good(OP_ESTAB);
      // unknown opcode
      push_good(BYTE_STX);
      push_good(BYTE_IND);
      push_good(8'h00);
      // wrong end byte drops the frame
      push_frame(OP_TRANSP, 16'h0000, 8'h00, 8'h00);
      // connect, then a failed release on a bad checksum, then release
      push_frame(OP_ESTAB, 16'h0000, 8'h00, BYTE_ETX);
      push_frame(OP_RELEASE, 16'h0000, 8'h80, BYTE_ETX);
      push_frame(OP_RELEASE, 16'h0002, 8'h00, BYTE_ETX);

      // random: mostly well-formed frames, some broken ones and noise
      good_bytes = 0;
      stim_hold = 1;
      while (good_bytes < 1150) begin
         ferr_pct = ($urandom_range(0, 2) == 0) ? 0 : 6;
         if ($urandom_range(0, 59) == 0) stim_hold = 1;
         kind = int'($urandom_range(0, 99));
         op = OPCODES[2'($urandom_range(0, 3))];
         if (kind < 65) begin
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(7, 40))
                                                : 16'($urandom_range(0, 6));
            end_byte = BYTE_ETX;
            if ($urandom_range(0, 9) == 0) begin
               end_byte = 8'($urandom_range(0, 255));
               if (end_byte == BYTE_ETX) end_byte = end_byte ^ 8'h01;
            end
            push_frame(op, len, 8'h00, end_byte);
         end else if (kind < 72) begin
            // any length goes here, the frame stops at the bad checksum
            len = 16'($urandom_range(0, 65535));
            push_frame(op, len, 8'($urandom_range(1, 255)), BYTE_ETX);
         end else if (kind < 78) begin
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_IND) b = b ^ 8'h01;
            push_good(BYTE_STX);
            push_good(b);
         end else if (kind < 84) begin
            b = 8'($urandom_range(0, 255));
            if (b inside {OP_READY, OP_ESTAB, OP_TRANSP, OP_RELEASE}) b = 8'hFF;
            push_good(BYTE_STX);
            push_good(BYTE_IND);
            push_good(b);
         end else if (kind < 92) begin
            noise_len = int'($urandom_range(1, 6));
            for (int i = 0; i < noise_len; i++) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b, 1'($urandom_range(0, 1)));
            end
         end else begin
            // stray start byte swallows the frame behind it
            push_good(BYTE_STX);
            push_frame(op, 16'($urandom_range(0, 3)), 8'h00, BYTE_ETX);
         end
      end

      // long payload, sent back to back once the bench is drained
      ferr_pct = 0;
      stim_hold = 1;
      stim_fast = 1;
      push_frame(OP_READY, 16'h0000, 8'h00, BYTE_ETX);
      push_frame(OP_ESTAB, 16'h0100, 8'h00, BYTE_ETX);
      stim_fast = 0;
      push_frame(OP_TRANSP, 16'h0001, 8'h00, BYTE_ETX);
      push_frame(OP_RELEASE, 16'h0000, 8'h00, BYTE_ETX);

      // reset once, then let the driver and monitor run
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("** radio_event_frame_link_tracker_top: PASSED **");
      end else begin
         $display("** radio_event_frame_link_tracker_top: FAILED **");
      end
      $finish;
   end

   // watchdog against a hung handshake
   initial begin : watchdog
      #10_000_000;
      $display("** radio_event_frame_link_tracker_top: FAILED **");
      $finish;
   end

endmodule
